@@ hdl/ffea_pkg.sv @@
// Shared types and constants of the first-fit extent allocator
`timescale 1ns / 1ps

package ffea_pkg;

  // field widths
  localparam int unsigned ADDR_W   = 40;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned RSIZE_W  = SIZE_W + 1;
  localparam int unsigned STATUS_W = 2;

  // page rounding
  localparam int unsigned PAGE_BYTES = 4096;
  localparam logic [RSIZE_W-1:0] PAGE_ROUND = RSIZE_W'(PAGE_BYTES - 1);
  localparam logic [RSIZE_W-1:0] PAGE_KEEP  = ~PAGE_ROUND;

  // reset value of the capacity register
  localparam logic [ADDR_W-1:0] CAPACITY_RESET = 40'd107374182400;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [RSIZE_W-1:0] rsize_t;

  // one free-list entry
  typedef struct packed {
    addr_t start;
    addr_t len;
  } hole_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_LISTFULL = 2'd2
  } status_e;

  // kind of pass over the free list
  typedef enum logic [1:0] {
    OP_FIND     = 2'd0,
    OP_INSERT   = 2'd1,
    OP_REINSERT = 2'd2
  } sweep_op_e;

  // request for one pass over the free list
  typedef struct packed {
    logic      start;
    sweep_op_e op;
    addr_t     key;
    addr_t     len;
    rsize_t    size;
  } sweep_cmd_t;

  // outcome of one pass
  typedef struct packed {
    logic  done;
    logic  found;
    logic  full;
    logic  wrap;
    addr_t base;
    addr_t wrap_start;
    addr_t rest;
  } sweep_res_t;

  // bytes rounded up to a whole page
  function automatic rsize_t round_to_page(input logic [SIZE_W-1:0] size);
    rsize_t sum;
    sum = RSIZE_W'(size) + PAGE_ROUND;
    return sum & PAGE_KEEP;
  endfunction

endpackage

@@ hdl/first_fit_extent_allocator_top.sv @@
// Top level of the first-fit extent allocator: handshakes, end pointer, cell chain
`timescale 1ns / 1ps

// First-fit extent allocator. Each transaction allocates (action 0) or frees
// (action 1) one extent; sizes are rounded up to 4096 bytes. The free list of
// FREE_SLOTS holes sits in a chain of cells that is rotated past a head
// processor for every transaction, which searches, deletes and inserts in
// offset order on the fly. A free, an allocation served from the end pointer
// and an allocation whose split stays below 2^40 take one rotation; an
// allocation whose remainder offset wraps past 2^40 needs a second rotation.
// The result sits in an output register, so a new transaction is taken while
// it waits. The user must write capacity_bytes through cfg_we_i only while the
// block is idle; the block itself does not enforce this. Holes are never
// coalesced.
module first_fit_extent_allocator_top #(
  parameter int unsigned FREE_SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [39:0] cfg_capacity_bytes_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [31:0] size_bytes_i,
  input  logic [39:0] release_offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [39:0] granted_offset_o,
  output logic [1:0]  status_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SWEEP = 4'b0010,
    S_WRAP  = 4'b0100,
    S_OUT   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  ffea_pkg::action_e    act_q;
  ffea_pkg::rsize_t     size_q, size_in;
  ffea_pkg::addr_t      cap_q, ep_q, gr_q, out_gr_q;
  ffea_pkg::status_e    st_q, out_st_q;
  logic                 use_end_q, out_valid_q;
  ffea_pkg::sweep_cmd_t cmd;
  ffea_pkg::sweep_res_t res;
  ffea_pkg::hole_t      emit;
  logic                 shift;
  ffea_pkg::hole_t      cell_q [FREE_SLOTS];

  logic                        in_fire, out_load, nospace;
  logic [ffea_pkg::ADDR_W:0]   ep_sum;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign size_in    = ffea_pkg::round_to_page(size_bytes_i);
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
  assign ep_sum     = {1'b0, ep_q} + (ffea_pkg::ADDR_W + 1)'(size_q);
  assign nospace    = (ep_sum > {1'b0, cap_q});

  // pass requests: a new transaction or the wrapped remainder
  always_comb begin
    cmd.start = 1'b0;
    cmd.op    = ffea_pkg::OP_REINSERT;
    cmd.key   = res.wrap_start;
    cmd.len   = res.rest;
    cmd.size  = size_q;
    if (state_q == S_IDLE) begin
      cmd.start = in_valid_i;
      cmd.op    = (ffea_pkg::action_e'(action_i) == ffea_pkg::ACT_FREE) ?
                  ffea_pkg::OP_INSERT : ffea_pkg::OP_FIND;
      cmd.key   = release_offset_i;
      cmd.len   = ffea_pkg::ADDR_W'(size_in);
      cmd.size  = size_in;
    end else if (state_q == S_SWEEP) begin
      cmd.start = res.done && (act_q == ffea_pkg::ACT_ALLOC) && res.found && res.wrap;
    end
  end

  // sequencing of one transaction
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (res.done) begin
          state_d = cmd.start ? S_WRAP : S_OUT;
        end
      end
      S_WRAP: begin
        if (res.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state, capacity, end pointer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= ffea_pkg::CAPACITY_RESET;
      ep_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_capacity_bytes_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        if (use_end_q && !nospace) begin
          ep_q <= ep_sum[ffea_pkg::ADDR_W-1:0];
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // transaction payload and result
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q  <= ffea_pkg::action_e'(action_i);
      size_q <= size_in;
    end
    if ((state_q == S_SWEEP) && res.done) begin
      use_end_q <= (act_q == ffea_pkg::ACT_ALLOC) && !res.found;
      gr_q      <= ((act_q == ffea_pkg::ACT_ALLOC) && res.found) ? res.base : '0;
      st_q      <= ((act_q == ffea_pkg::ACT_FREE) && res.full) ?
                   ffea_pkg::ST_LISTFULL : ffea_pkg::ST_OK;
    end
    if (out_load) begin
      if (use_end_q) begin
        out_gr_q <= nospace ? '0 : ep_q;
        out_st_q <= nospace ? ffea_pkg::ST_NOSPACE : ffea_pkg::ST_OK;
      end else begin
        out_gr_q <= gr_q;
        out_st_q <= st_q;
      end
    end
  end

  // head processor
  ffea_sweep #(
    .FREE_SLOTS(FREE_SLOTS)
  ) u_sweep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .head0_i (cell_q[0]),
    .head1_i (cell_q[1]),
    .emit_o  (emit),
    .shift_o (shift),
    .res_o   (res)
  );

  // rotating chain of free-list cells
  for (genvar k = 0; k < FREE_SLOTS; k++) begin : g_cell
    if (k == FREE_SLOTS - 1) begin : g_tail
      ffea_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .data_i  (emit),
        .data_o  (cell_q[k])
      );
    end else begin : g_body
      ffea_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .data_i  (cell_q[k+1]),
        .data_o  (cell_q[k])
      );
    end
  end

  assign out_valid_o      = out_valid_q;
  assign granted_offset_o = out_gr_q;
  assign status_o         = out_st_q;

endmodule

@@ hdl/ffea_cell.sv @@
// One free-list entry of the rotating cell chain
`timescale 1ns / 1ps

module ffea_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  ffea_pkg::hole_t data_i,
  output ffea_pkg::hole_t data_o
);

  ffea_pkg::hole_t hole_q;

  // take the next cell's entry (the head processor's output at the tail) on every rotation step
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      hole_q <= data_i;
    end
  end

  assign data_o = hole_q;

endmodule

@@ hdl/ffea_sweep.sv @@
// Head-of-chain processor: search, delete and ordered insert while the list rotates
`timescale 1ns / 1ps

module ffea_sweep #(
  parameter int unsigned FREE_SLOTS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ffea_pkg::sweep_cmd_t cmd_i,
  input  ffea_pkg::hole_t      head0_i,
  input  ffea_pkg::hole_t      head1_i,
  output ffea_pkg::hole_t      emit_o,
  output logic                 shift_o,
  output ffea_pkg::sweep_res_t res_o
);

  localparam int unsigned IDX_W = $clog2(FREE_SLOTS);
  localparam int unsigned CNT_W = $clog2(FREE_SLOTS + 1);

  // offset between emitted slot and the list entry under consideration
  typedef enum logic [2:0] {
    LAG_ALIGN  = 3'b001,
    LAG_AHEAD  = 3'b010,
    LAG_BEHIND = 3'b100
  } lag_e;

  logic             busy_q, done_q;
  logic [IDX_W-1:0] t_q;
  lag_e             lag_q, lag_d;
  logic             find_q, find_d, pend_q, pend_d, chk_full_q;
  logic             add_q, add_d, del_q, del_d;
  logic             found_q, found_d, full_q, full_d, wrap_q, wrap_d;
  logic [CNT_W-1:0] count_q, count_d;

  ffea_pkg::hole_t   carry_q, carry_d;
  ffea_pkg::addr_t   key_q, key_d, len_q, len_d;
  ffea_pkg::addr_t   base_q, base_d, wstart_q, wstart_d, rest_q, rest_d;
  ffea_pkg::rsize_t  size_q;

  ffea_pkg::hole_t              cur;
  logic                         cur_vld, nxt_vld, last, list_full, fit;
  logic [CNT_W-1:0]             t_ext, cur_idx;
  ffea_pkg::addr_t              size_ext, rest_w;
  logic [ffea_pkg::ADDR_W:0]    sum_w;
  ffea_pkg::hole_t              emit;

  assign last      = (t_q == IDX_W'(FREE_SLOTS - 1));
  assign t_ext     = CNT_W'(t_q);
  assign list_full = (count_q == CNT_W'(FREE_SLOTS));
  assign nxt_vld   = ((t_ext + CNT_W'(1)) < count_q);
  assign size_ext  = ffea_pkg::ADDR_W'(size_q);

  // entry under consideration and its list index
  always_comb begin
    unique case (lag_q)
      LAG_ALIGN: begin
        cur     = head0_i;
        cur_idx = t_ext;
      end
      LAG_AHEAD: begin
        cur     = head1_i;
        cur_idx = t_ext + CNT_W'(1);
      end
      LAG_BEHIND: begin
        cur     = carry_q;
        cur_idx = t_ext - CNT_W'(1);
      end
      default: begin
        cur     = head0_i;
        cur_idx = t_ext;
      end
    endcase
  end

  assign cur_vld = (cur_idx < count_q);
  assign fit     = find_q && cur_vld && (cur.len >= size_ext);
  assign rest_w  = cur.len - size_ext;
  assign sum_w   = {1'b0, cur.start} + (ffea_pkg::ADDR_W + 1)'(size_q);

  // decide what goes into the tail cell this step
  always_comb begin
    emit     = cur;
    lag_d    = lag_q;
    carry_d  = (lag_q == LAG_BEHIND) ? head0_i : carry_q;
    find_d   = find_q;
    pend_d   = pend_q;
    add_d    = add_q;
    del_d    = del_q;
    found_d  = found_q;
    full_d   = full_q;
    wrap_d   = wrap_q;
    key_d    = key_q;
    len_d    = len_q;
    base_d   = base_q;
    wstart_d = wstart_q;
    rest_d   = rest_q;
    if (pend_q && (!cur_vld || (cur.start >= key_q))) begin
      pend_d = 1'b0;
      priority if (cur_vld && (cur.start == key_q)) begin
        emit.start = cur.start;
        emit.len   = len_q;
      end else if (chk_full_q && list_full) begin
        full_d = 1'b1;
      end else begin
        emit.start = key_q;
        emit.len   = len_q;
        add_d      = 1'b1;
        if (lag_q == LAG_ALIGN) begin
          lag_d   = LAG_BEHIND;
          carry_d = head0_i;
        end else begin
          lag_d = LAG_ALIGN;
        end
      end
    end else if (fit) begin
      // first fit: drop it, the remainder goes back in order
      find_d  = 1'b0;
      found_d = 1'b1;
      del_d   = 1'b1;
      base_d  = cur.start;
      priority if (rest_w == '0) begin
        emit  = head1_i;
        lag_d = LAG_AHEAD;
      end else if (sum_w[ffea_pkg::ADDR_W]) begin
        // remainder offset wraps, reinserted by a second pass
        emit     = head1_i;
        lag_d    = LAG_AHEAD;
        wrap_d   = 1'b1;
        wstart_d = sum_w[ffea_pkg::ADDR_W-1:0];
        rest_d   = rest_w;
      end else if (!nxt_vld || (head1_i.start > sum_w[ffea_pkg::ADDR_W-1:0])) begin
        emit.start = sum_w[ffea_pkg::ADDR_W-1:0];
        emit.len   = rest_w;
        add_d      = 1'b1;
      end else if (head1_i.start == sum_w[ffea_pkg::ADDR_W-1:0]) begin
        emit.start = head1_i.start;
        emit.len   = rest_w;
        lag_d      = LAG_AHEAD;
      end else begin
        emit   = head1_i;
        lag_d  = LAG_AHEAD;
        pend_d = 1'b1;
        key_d  = sum_w[ffea_pkg::ADDR_W-1:0];
        len_d  = rest_w;
      end
    end
    // insert never placed on a full list
    if (last && pend_d && chk_full_q) begin
      full_d = 1'b1;
    end
  end

  assign count_d = count_q + CNT_W'(add_d) - CNT_W'(del_d);

  // pass control and entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      done_q     <= 1'b0;
      t_q        <= '0;
      lag_q      <= LAG_ALIGN;
      find_q     <= 1'b0;
      pend_q     <= 1'b0;
      chk_full_q <= 1'b0;
      add_q      <= 1'b0;
      del_q      <= 1'b0;
      found_q    <= 1'b0;
      full_q     <= 1'b0;
      wrap_q     <= 1'b0;
      count_q    <= '0;
    end else begin
      done_q <= busy_q && last;
      if (cmd_i.start) begin
        busy_q     <= 1'b1;
        t_q        <= '0;
        lag_q      <= LAG_ALIGN;
        find_q     <= (cmd_i.op == ffea_pkg::OP_FIND);
        pend_q     <= (cmd_i.op != ffea_pkg::OP_FIND);
        chk_full_q <= (cmd_i.op == ffea_pkg::OP_INSERT);
        add_q      <= 1'b0;
        del_q      <= 1'b0;
        found_q    <= 1'b0;
        full_q     <= 1'b0;
        wrap_q     <= 1'b0;
      end else if (busy_q) begin
        t_q     <= t_q + IDX_W'(1);
        lag_q   <= lag_d;
        find_q  <= find_d;
        pend_q  <= pend_d;
        add_q   <= add_d;
        del_q   <= del_d;
        found_q <= found_d;
        full_q  <= full_d;
        wrap_q  <= wrap_d;
        if (last) begin
          busy_q  <= 1'b0;
          count_q <= count_d;
        end
      end
    end
  end

  // pass payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q  <= cmd_i.key;
      len_q  <= cmd_i.len;
      size_q <= cmd_i.size;
    end else if (busy_q) begin
      carry_q  <= carry_d;
      key_q    <= key_d;
      len_q    <= len_d;
      base_q   <= base_d;
      wstart_q <= wstart_d;
      rest_q   <= rest_d;
    end
  end

  assign emit_o  = emit;
  assign shift_o = busy_q;

  assign res_o.done       = done_q;
  assign res_o.found      = found_q;
  assign res_o.full       = full_q;
  assign res_o.wrap       = wrap_q;
  assign res_o.base       = base_q;
  assign res_o.wrap_start = wstart_q;
  assign res_o.rest       = rest_q;

endmodule
